// File: rtl/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg
// Shared sizes, codes and types of the keyframe track evaluator.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int TRACKS         = 8;
  localparam int KEYS_PER_TRACK = 32;
  localparam int FRAME_BITS     = 24;

  localparam int TRK_W   = $clog2(TRACKS);
  localparam int TCNT_W  = TRK_W + 1;
  localparam int KIDX_W  = $clog2(KEYS_PER_TRACK);
  localparam int KCNT_W  = KIDX_W + 1;
  localparam int KADDR_W = TRK_W + KIDX_W;
  localparam int KDEPTH  = TRACKS * KEYS_PER_TRACK;
  localparam int LEVEL_W = 8;
  localparam int CHAN_W  = 10;
  localparam int PROD_W  = LEVEL_W + FRAME_BITS;

  typedef enum logic [1:0] {
    CMD_ADD_TRACK = 2'd0,
    CMD_ADD_KEY   = 2'd1,
    CMD_EVAL      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_TRACK = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_EV_TRK,
    S_EV_RD,
    S_EV_CMP,
    S_EV_MUL,
    S_EV_DIV,
    S_EV_OUT,
    S_ACK
  } fsm_e;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [LEVEL_W-1:0]    level;
    logic                  mode;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic                  start;
    logic [PROD_W-1:0]     dividend;
    logic [FRAME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/keyframe_track_evaluator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_track_evaluator_unit
// Keyframe tracks for lighting channels with step or linear evaluation.
// ----------------------------------------------------------------------------
// Usage:
//   One input beat carries one command, selected by s_axis_tuser: add a
//   track bound to a channel, insert a keyframe into a track, or evaluate
//   one frame. Add-track and add-keyframe return one acknowledgement beat
//   (status in m_axis_tuser, tlast high). Evaluate returns one beat per
//   keyed track in track order, tlast on the final one, none if no track
//   has keyframes.
//   Sequence: an add-track goes from idle to the acknowledge state. An
//   insert moves each later keyframe up one slot, then writes the new
//   one. An evaluation walks each track's list, reading its keyframes
//   from the key RAM in turn; a linear segment adds a multiply step and
//   a run of the divider.
//   One command is worked on at a time; s_axis_tready is high only while
//   the sequencer is idle, including while a result beat still waits.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset clears the track count and all key counts; key RAM contents need
//   no clearing, since only written entries are read.
// ----------------------------------------------------------------------------
module keyframe_track_evaluator_unit import kte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] track_index, [12:3] dmx_channel, [36:13] frame_number,
  // [44:37] node_value, [45] lerp_mode, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] out_channel, [17:10] out_value, [23:18] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  // Input unpack
  logic [2:0]            in_tix;
  logic [CHAN_W-1:0]     in_chan;
  logic [FRAME_BITS-1:0] in_frame;
  logic [LEVEL_W-1:0]    in_level;
  logic                  in_mode;
  logic                  in_fire;

  assign in_tix   = s_axis_tdata[2:0];
  assign in_chan  = s_axis_tdata[12:3];
  assign in_frame = s_axis_tdata[13 +: FRAME_BITS];
  assign in_level = s_axis_tdata[37 +: LEVEL_W];
  assign in_mode  = s_axis_tdata[45];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // State
  fsm_e                  state_q, state_d;
  logic [2:0]            tix_q, tix_d;
  logic [FRAME_BITS-1:0] f_q, f_d;
  logic [LEVEL_W-1:0]    lvl_q, lvl_d;
  logic                  mode_q, mode_d;
  logic [KCNT_W-1:0]     idx_q, idx_d;
  logic [TCNT_W-1:0]     trk_q, trk_d;
  key_t                  prev_q, prev_d;
  logic [LEVEL_W-1:0]    a_q, a_d;
  logic [LEVEL_W-1:0]    dmag_q, dmag_d;
  logic                  neg_q, neg_d;
  logic [FRAME_BITS-1:0] span_q, span_d;
  logic [FRAME_BITS-1:0] den_q, den_d;
  logic [LEVEL_W-1:0]    res_q, res_d;
  status_e               stat_q, stat_d;
  logic [TCNT_W-1:0]     tcnt_q;
  logic [CHAN_W-1:0]     chan_q [TRACKS];
  logic [KCNT_W-1:0]     kcnt_q [TRACKS];

  // Output register
  logic                  ovalid_q;
  logic [CHAN_W-1:0]     ochan_q;
  logic [LEVEL_W-1:0]    olevel_q;
  status_e               ostat_q;
  logic                  olast_q;
  logic                  out_free;
  logic                  out_load;
  logic [CHAN_W-1:0]     out_chan;
  logic [LEVEL_W-1:0]    out_level;
  status_e               out_stat;
  logic                  out_last;

  // Bookkeeping strobes
  logic                  track_add;
  logic                  key_add;

  // Key RAM and divider
  logic                  ram_we, ram_re;
  logic [KADDR_W-1:0]    ram_waddr, ram_raddr;
  key_t                  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]      ram_rdata_raw;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [TRK_W-1:0]      ins_t, ev_t;
  logic [KCNT_W-1:0]     ins_n, ev_n;
  logic                  more_keyed;
  logic [LEVEL_W:0]      diff;
  logic [LEVEL_W-1:0]    q8;

  assign ins_t    = tix_q[TRK_W-1:0];
  assign ev_t     = trk_q[TRK_W-1:0];
  assign ins_n    = kcnt_q[ins_t];
  assign ev_n     = kcnt_q[ev_t];
  assign out_free = !ovalid_q || m_axis_tready;
  assign ram_rdata = key_t'(ram_rdata_raw);

  kte_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KDEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  kte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Any keyed track after the current one decides tlast of an evaluation.
  always_comb begin
    more_keyed = 1'b0;
    for (int t = 0; t < TRACKS; t++) begin
      if ((TCNT_W'(t) > trk_q) && (TCNT_W'(t) < tcnt_q) && (kcnt_q[t] != '0)) begin
        more_keyed = 1'b1;
      end
    end
  end

  // Next state and datapath registers
  always_comb begin
    state_d   = state_q;
    tix_d     = tix_q;
    f_d       = f_q;
    lvl_d     = lvl_q;
    mode_d    = mode_q;
    idx_d     = idx_q;
    trk_d     = trk_q;
    prev_d    = prev_q;
    a_d       = a_q;
    dmag_d    = dmag_q;
    neg_d     = neg_q;
    span_d    = span_q;
    den_d     = den_q;
    res_d     = res_q;
    stat_d    = stat_q;
    track_add = 1'b0;
    key_add   = 1'b0;
    diff      = {1'b0, ram_rdata.level} - {1'b0, prev_q.level};
    q8        = div_rsp.quotient[LEVEL_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          tix_d  = in_tix;
          f_d    = in_frame;
          lvl_d  = in_level;
          mode_d = in_mode;
          priority case (s_axis_tuser)
            CMD_ADD_TRACK: begin
              if (tcnt_q >= TCNT_W'(TRACKS)) begin
                stat_d = STAT_FULL;
              end else begin
                stat_d    = STAT_OK;
                track_add = 1'b1;
              end
              state_d = S_ACK;
            end
            CMD_ADD_KEY: state_d = S_INS_CHK;
            CMD_EVAL: begin
              trk_d   = '0;
              state_d = S_EV_TRK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: begin
        if ({1'b0, tix_q} >= tcnt_q) begin
          stat_d  = STAT_BAD_TRACK;
          state_d = S_ACK;
        end else if (ins_n >= KCNT_W'(KEYS_PER_TRACK)) begin
          stat_d  = STAT_FULL;
          state_d = S_ACK;
        end else begin
          idx_d   = ins_n;
          state_d = (ins_n == '0) ? S_INS_WR : S_INS_RD;
        end
      end
      S_INS_RD: state_d = S_INS_CMP;
      S_INS_CMP: begin
        // Move a later keyframe up one slot, or stop and place the new one.
        if (ram_rdata.frame > f_q) begin
          idx_d   = idx_q - KCNT_W'(1);
          state_d = (idx_q == KCNT_W'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        key_add = 1'b1;
        stat_d  = STAT_OK;
        state_d = S_ACK;
      end
      S_EV_TRK: begin
        if (trk_q >= tcnt_q) begin
          state_d = S_IDLE;
        end else if (ev_n == '0) begin
          trk_d = trk_q + TCNT_W'(1);
        end else begin
          idx_d   = '0;
          state_d = S_EV_RD;
        end
      end
      S_EV_RD: state_d = S_EV_CMP;
      S_EV_CMP: begin
        if (ram_rdata.frame > f_q) begin
          if (idx_q == '0) begin
            res_d   = '0;
            state_d = S_EV_OUT;
          end else if (!prev_q.mode) begin
            res_d   = prev_q.level;
            state_d = S_EV_OUT;
          end else begin
            a_d     = prev_q.level;
            neg_d   = diff[LEVEL_W];
            dmag_d  = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
            span_d  = f_q - prev_q.frame;
            den_d   = ram_rdata.frame - prev_q.frame;
            state_d = S_EV_MUL;
          end
        end else if (idx_q + KCNT_W'(1) == ev_n) begin
          res_d   = ram_rdata.level;
          state_d = S_EV_OUT;
        end else begin
          prev_d  = ram_rdata;
          idx_d   = idx_q + KCNT_W'(1);
          state_d = S_EV_RD;
        end
      end
      S_EV_MUL: state_d = S_EV_DIV;
      S_EV_DIV: begin
        if (div_rsp.done) begin
          res_d   = neg_q ? (a_q - q8) : (a_q + q8);
          state_d = S_EV_OUT;
        end
      end
      S_EV_OUT: begin
        if (out_free) begin
          trk_d   = trk_q + TCNT_W'(1);
          state_d = S_EV_TRK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM port, divider, result load
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = {ins_t, idx_q[KIDX_W-1:0]};
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = {ev_t, idx_q[KIDX_W-1:0]};
    div_req       = '0;
    out_load      = 1'b0;
    out_chan      = '0;
    out_level     = '0;
    out_stat      = stat_q;
    out_last      = 1'b1;

    unique case (state_q)
      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {ins_t, idx_q[KIDX_W-1:0] - KIDX_W'(1)};
      end
      S_INS_CMP: begin
        ram_we = (ram_rdata.frame > f_q);
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{frame: f_q, level: lvl_q, mode: mode_q};
      end
      S_EV_RD: ram_re = 1'b1;
      S_EV_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = PROD_W'(dmag_q * span_q);
        div_req.divisor  = den_q;
      end
      S_EV_OUT: begin
        out_load  = out_free;
        out_chan  = chan_q[ev_t];
        out_level = res_q;
        out_stat  = STAT_OK;
        out_last  = !more_keyed;
      end
      S_ACK: out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tcnt_q   <= '0;
      ovalid_q <= 1'b0;
      trk_q    <= '0;
      idx_q    <= '0;
      for (int t = 0; t < TRACKS; t++) begin
        kcnt_q[t] <= '0;
      end
    end else begin
      state_q <= state_d;
      trk_q   <= trk_d;
      idx_q   <= idx_d;
      if (track_add) begin
        tcnt_q                    <= tcnt_q + TCNT_W'(1);
        kcnt_q[tcnt_q[TRK_W-1:0]] <= '0;
      end
      if (key_add) begin
        kcnt_q[ins_t] <= ins_n + KCNT_W'(1);
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tix_q  <= tix_d;
    f_q    <= f_d;
    lvl_q  <= lvl_d;
    mode_q <= mode_d;
    prev_q <= prev_d;
    a_q    <= a_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    span_q <= span_d;
    den_q  <= den_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    if (track_add) begin
      chan_q[tcnt_q[TRK_W-1:0]] <= in_chan;
    end
    if (out_load) begin
      ochan_q  <= out_chan;
      olevel_q <= out_level;
      ostat_q  <= out_stat;
      olast_q  <= out_last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'b0, olevel_q, ochan_q};
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;

  // Checks
  a_tcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= TCNT_W'(TRACKS))
    else $error("track count beyond table size");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_ram_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("key RAM read and write to one entry");

endmodule

// File: rtl/kte_ram.sv
// ----------------------------------------------------------------------------
// kte_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/kte_div.sv
// ----------------------------------------------------------------------------
// kte_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kte_div import kte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [FRAME_BITS:0]   rem_q, rem_d;
  logic [PROD_W-1:0]     quo_q, quo_d;
  logic [FRAME_BITS-1:0] den_q, den_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [FRAME_BITS:0]   rem_sh;
  logic [FRAME_BITS+1:0] trial;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q[FRAME_BITS-1:0], quo_q[PROD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~trial[FRAME_BITS+1];
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = CNT_W'(PROD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[FRAME_BITS:0] : rem_sh;
      quo_d = {quo_q[PROD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: test/keyframe_track_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_track_evaluator_unit_tb
// Drives directed and random track, keyframe, evaluate and unused commands
// with random gaps on the input and random stalls on the output. A
// behavioral copy of the track tables predicts every result beat, and the
// monitor compares each beat with the oldest prediction.
// ----------------------------------------------------------------------------
module keyframe_track_evaluator_unit_tb;
  import kte_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [2:0]            trk;
    logic [CHAN_W-1:0]     chan;
    logic [FRAME_BITS-1:0] frame;
    logic [LEVEL_W-1:0]    level;
    logic                  mode;
  } cmd_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic [1:0]         status;
    logic               last;
  } rsp_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  keyframe_track_evaluator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  int unsigned            n_tracks;
  logic [CHAN_W-1:0]      trk_chan [TRACKS];
  int unsigned            n_keys [TRACKS];
  logic [FRAME_BITS-1:0]  kf_frame [TRACKS][KEYS_PER_TRACK];
  logic [LEVEL_W-1:0]     kf_level [TRACKS][KEYS_PER_TRACK];
  logic                   kf_mode [TRACKS][KEYS_PER_TRACK];

  cmd_beat_t pending_cmds[$];
  rsp_beat_t expected_rsps[$];
  int unsigned mismatches = 0;
  int unsigned rsp_seen = 0;
  int unsigned eval_beats = 0;
  int unsigned n_cmds = 0;

  function automatic logic [LEVEL_W-1:0] level_at(int t, logic [FRAME_BITS-1:0] f);
    int i;
    longint a, b, fa, fb, r;
    i = 0;
    while (i < n_keys[t] && kf_frame[t][i] <= f) i++;
    if (i == n_keys[t]) return kf_level[t][i-1];
    if (i == 0) return '0;
    if (!kf_mode[t][i-1]) return kf_level[t][i-1];
    a = kf_level[t][i-1]; b = kf_level[t][i];
    fa = kf_frame[t][i-1]; fb = kf_frame[t][i];
    r = a + ((b - a) * (longint'(f) - fa)) / (fb - fa);
    return r[7:0];
  endfunction

  task automatic apply_command(cmd_beat_t c);
    rsp_beat_t r;
    int pos, first;
    r = '{chan: '0, level: '0, status: STAT_OK, last: 1'b1};
    case (c.cmd)
      CMD_ADD_TRACK: begin
        if (n_tracks >= TRACKS) r.status = STAT_FULL;
        else begin
          trk_chan[n_tracks] = c.chan;
          n_keys[n_tracks] = 0;
          n_tracks++;
        end
        expected_rsps.push_back(r);
      end
      CMD_ADD_KEY: begin
        if (c.trk >= n_tracks) r.status = STAT_BAD_TRACK;
        else if (n_keys[c.trk] >= KEYS_PER_TRACK) r.status = STAT_FULL;
        else begin
          pos = n_keys[c.trk];
          // shift later keyframes up; equal frames stay ahead
          while (pos > 0 && kf_frame[c.trk][pos-1] > c.frame) begin
            kf_frame[c.trk][pos] = kf_frame[c.trk][pos-1];
            kf_level[c.trk][pos] = kf_level[c.trk][pos-1];
            kf_mode[c.trk][pos] = kf_mode[c.trk][pos-1];
            pos--;
          end
          kf_frame[c.trk][pos] = c.frame;
          kf_level[c.trk][pos] = c.level;
          kf_mode[c.trk][pos] = c.mode;
          n_keys[c.trk]++;
        end
        expected_rsps.push_back(r);
      end
      CMD_EVAL: begin
        first = expected_rsps.size();
        for (int t = 0; t < n_tracks; t++) begin
          if (n_keys[t] == 0) continue;
          r.chan = trk_chan[t];
          r.level = level_at(t, c.frame);
          r.last = 1'b0;
          expected_rsps.push_back(r);
          eval_beats++;
        end
        if (expected_rsps.size() > first)
          expected_rsps[expected_rsps.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic cmd_beat_t rand_cmd(int unsigned kind);
    cmd_beat_t c;
    c.cmd = kind[1:0];
    c.trk = 3'($urandom_range(0, 7));
    c.chan = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom)
                                         : CHAN_W'($urandom_range(1, 512));
    // mostly small frames so keyframes collide and interleave
    case ($urandom_range(0, 3))
      0: c.frame = FRAME_BITS'($urandom);
      1: c.frame = FRAME_BITS'($urandom_range(0, 40));
      default: c.frame = FRAME_BITS'($urandom_range(0, 2000));
    endcase
    c.level = LEVEL_W'($urandom);
    c.mode = 1'($urandom);
    return c;
  endfunction

  // Latch the handshake at the rising edge for the driver.
  logic s_axis_tready_q = 1'b0;
  always @(posedge clk_i) s_axis_tready_q <= s_axis_tready;

  // Driver: present queued commands, with random gaps.
  int unsigned drv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        apply_command(pending_cmds.pop_front());
        s_axis_tvalid <= 1'b0;
        drv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) drv_gap = 0;
      end else if (!s_axis_tvalid && pending_cmds.size() > 0) begin
        if (drv_gap > 0) drv_gap--;
        else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_cmds[0].cmd;
          s_axis_tdata <= {2'b0, pending_cmds[0].mode, pending_cmds[0].level,
                           pending_cmds[0].frame, pending_cmds[0].chan, pending_cmds[0].trk};
        end
      end
    end
  end

  // Monitor: compare each accepted result beat.
  always @(posedge clk_i) begin
    rsp_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{chan: m_axis_tdata[9:0], level: m_axis_tdata[17:10],
              status: m_axis_tuser, last: m_axis_tlast};
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat ch=%0d lvl=%0d st=%0d last=%0b",
                                       got.chan, got.level, got.status, got.last);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want || m_axis_tdata[23:18] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ch=%0d lvl=%0d st=%0d last=%0b, ",
                      "got ch=%0d lvl=%0d st=%0d last=%0b"},
                     want.chan, want.level, want.status, want.last,
                     got.chan, got.level, got.status, got.last);
        end
      end
    end
  end

  int unsigned stall = 0;
  always @(negedge clk_i) begin
    if (stall > 0) begin
      stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  initial begin
    cmd_beat_t c;
    int unsigned p;
    // Directed: before any track, bad index, empty evaluate, extremes.
    c = rand_cmd(CMD_EVAL); pending_cmds.push_back(c);
    c = rand_cmd(CMD_ADD_KEY); c.trk = 0; pending_cmds.push_back(c);
    c = rand_cmd(CMD_UNUSED); pending_cmds.push_back(c);
    c = rand_cmd(CMD_ADD_TRACK); c.chan = 1; pending_cmds.push_back(c);
    c = rand_cmd(CMD_ADD_TRACK); c.chan = 512; pending_cmds.push_back(c);
    c = rand_cmd(CMD_ADD_TRACK); c.chan = 10'h3FF; pending_cmds.push_back(c);
    c = rand_cmd(CMD_EVAL); pending_cmds.push_back(c);  // tracks but no keys
    c = rand_cmd(CMD_ADD_KEY); c.trk = 7; pending_cmds.push_back(c);
    c = rand_cmd(CMD_ADD_KEY); c.trk = 0; c.frame = 100; c.level = 0; c.mode = 1;
    pending_cmds.push_back(c);
    c.frame = 200; c.level = 255; c.mode = 1; pending_cmds.push_back(c);
    c.frame = 100; c.level = 77; c.mode = 0; pending_cmds.push_back(c);  // equal frame
    c.trk = 1; c.frame = '1; c.level = 255; pending_cmds.push_back(c);
    c.trk = 1; c.frame = 0; c.level = 9; c.mode = 1; pending_cmds.push_back(c);
    c = rand_cmd(CMD_EVAL); c.frame = 0; pending_cmds.push_back(c);
    c.frame = 99; pending_cmds.push_back(c);
    c.frame = 150; pending_cmds.push_back(c);
    c.frame = 200; pending_cmds.push_back(c);
    c.frame = '1; pending_cmds.push_back(c);
    c.frame = 24'h7FFFFF; pending_cmds.push_back(c);
    c.frame = 24'hFFFFFE; pending_cmds.push_back(c);
    // Fill track 2 past capacity to reach the full status.
    for (int i = 0; i < KEYS_PER_TRACK + 1; i++) begin
      c = rand_cmd(CMD_ADD_KEY); c.trk = 2; pending_cmds.push_back(c);
    end
    // Random part; most keyframe inserts target existing tracks.
    for (int i = 0; i < 400; i++) begin
      p = $urandom_range(0, 99);
      if (p < 6) c = rand_cmd(CMD_ADD_TRACK);
      else if (p < 55) c = rand_cmd(CMD_ADD_KEY);
      else if (p < 97) c = rand_cmd(CMD_EVAL);
      else c = rand_cmd(CMD_UNUSED);
      if (c.cmd == CMD_ADD_KEY && $urandom_range(0, 9) != 0) c.trk = 3'($urandom_range(0, 5));
      pending_cmds.push_back(c);
    end
    n_cmds = pending_cmds.size();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !s_axis_tvalid);
    wait (expected_rsps.size() == 0);
    repeat (2000) @(posedge clk_i);
    $display("Ran %0d commands, checked %0d result beats (%0d evaluation levels).",
             n_cmds, rsp_seen, eval_beats);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, expected_rsps.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout waiting for the unit to drain");
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/kte_pkg.sv
rtl/kte_ram.sv
rtl/kte_div.sv
rtl/keyframe_track_evaluator_unit.sv
test/keyframe_track_evaluator_unit_tb.sv
